/* rtl/core/imu_complementary_filter_macros.svh */
// Assertion macros shared by the filter RTL.
`ifndef IMU_COMPLEMENTARY_FILTER_MACROS_SVH
`define IMU_COMPLEMENTARY_FILTER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define IMU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define IMU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/imucf_pkg.sv */
// ----------------------------------------------------------------------------
// imucf_pkg
// Types, constants and the CORDIC angle table for the attitude filter.
// ----------------------------------------------------------------------------
package imucf_pkg;

  localparam int unsigned AtanIterDefault = 16;
  localparam int unsigned AtanTabDepth    = 24;
  localparam int unsigned CfgIdxW         = 2;
  localparam int unsigned CfgDataW        = 21;

  localparam logic [CfgIdxW-1:0] CfgBlendWeight  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStepTime     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFilterEnable = 2'd2;

  localparam logic [16:0] BlendReset = 17'd58982;
  localparam logic [20:0] StepReset  = 21'd83886;
  localparam logic [16:0] OneQ16     = 17'd65536;
  localparam logic signed [31:0] Deg90Q16 = 32'sd5898240;

  typedef struct packed {
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] roll_deg;
    logic signed [31:0] pitch_deg;
    logic signed [31:0] yaw_deg;
  } attitude_t;

  // Handshake between the sequencer and the CORDIC unit.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } cordic_ctrl_t;

  typedef enum logic [3:0] {
    StIdle, StRoll, StRollWait, StPitch, StPitchWait,
    StGyro, StGyroSum, StMulA, StMulB, StBlend, StOut
  } seq_state_e;

  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    logic signed [31:0] v;
    begin
      unique case (i)
        5'd0: v = 32'sd2949120;   5'd1: v = 32'sd1740967;
        5'd2: v = 32'sd919879;    5'd3: v = 32'sd466945;
        5'd4: v = 32'sd234379;    5'd5: v = 32'sd117304;
        5'd6: v = 32'sd58666;     5'd7: v = 32'sd29335;
        5'd8: v = 32'sd14668;     5'd9: v = 32'sd7334;
        5'd10: v = 32'sd3667;     5'd11: v = 32'sd1833;
        5'd12: v = 32'sd917;      5'd13: v = 32'sd458;
        5'd14: v = 32'sd229;      5'd15: v = 32'sd115;
        5'd16: v = 32'sd57;       5'd17: v = 32'sd29;
        5'd18: v = 32'sd14;       5'd19: v = 32'sd7;
        5'd20: v = 32'sd4;        5'd21: v = 32'sd2;
        5'd22: v = 32'sd1;
        default: v = 32'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

/* rtl/core/imucf_stream_if.sv */
// ----------------------------------------------------------------------------
// imucf_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface imucf_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/imu_complementary_filter.sv */
// ----------------------------------------------------------------------------
// imu_complementary_filter
// Complementary roll/pitch/yaw filter over one six-axis IMU sample.
// ----------------------------------------------------------------------------
// A sample's result is posted after the steps below, and the next sample can
// be accepted when the sequencer is back in idle after posting it. The work
// goes to two atan2 passes through one iterative CORDIC unit, then three gyro
// terms, a settle state and three blend steps, each through StMulA, StMulB
// and StBlend, on one shared 34x18 multiplier. The input is not ready while a
// sample is worked on. The result sits in an output register until taken; the
// next sample may be accepted meanwhile, and its own result waits until the
// register is free. When filtering is disabled the held angles are posted
// without a filter pass, once the output register is free.
`include "imu_complementary_filter_macros.svh"
module imu_complementary_filter #(
  parameter int unsigned AtanIterations = imucf_pkg::AtanIterDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [imucf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [imucf_pkg::CfgDataW-1:0] cfg_data_i,
  imucf_stream_if.sink                   in_if,
  imucf_stream_if.source                 out_if
);
  import imucf_pkg::*;

  logic [16:0] alpha_q;
  logic [20:0] dt_q;
  logic        en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= BlendReset; dt_q <= StepReset; en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBlendWeight:  alpha_q <= cfg_data_i[16:0];
        CfgStepTime:     dt_q <= cfg_data_i;
        CfgFilterEnable: en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  seq_state_e st_q, st_d;
  sample_t smp_q;
  logic signed [31:0] acc_q [3];
  logic signed [31:0] ang_q [2];
  logic signed [47:0] gsum_q [3];
  logic signed [65:0] blend_q;
  logic [1:0]  ch_q, ch_d;
  logic        out_v_q;
  attitude_t   out_q;
  logic        out_free;

  logic         cstart;
  logic signed [16:0] cy, cx;
  cordic_ctrl_t cctrl;
  logic signed [31:0] cang;

  imucf_cordic #(.AtanIterations(AtanIterations)) u_cordic (
    .clk_i, .rst_ni, .start_i(cstart), .y_i(cy), .x_i(cx),
    .ctrl_o(cctrl), .angle_o(cang)
  );

  // Shared multiplier: the upper 34 bits of the gyro term, or the
  // accelerometer angle, times an 18-bit blend weight.
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] mul_p;
  logic signed [51:0] prod_q;
  logic [16:0] alpha_c;
  logic signed [47:0] gcur;
  logic signed [31:0] acur;
  logic signed [65:0] bnext;
  logic signed [49:0] bshift;

  always_comb begin
    alpha_c = (alpha_q > OneQ16) ? OneQ16 : alpha_q;
    gcur = gsum_q[ch_q];
    acur = (ch_q == 2'd2) ? 32'sd0 : ang_q[ch_q[0]];
    mul_a = '0; mul_b = '0;
    unique case (st_q)
      StGyro: begin
        unique case (ch_q)
          2'd0: mul_a = 34'(smp_q.rate_x);
          2'd1: mul_a = 34'(smp_q.rate_y);
          default: mul_a = 34'(smp_q.rate_z);
        endcase
        mul_b = 18'sd0; // unused; rate*dt formed below
      end
      StMulA: begin mul_a = gcur[47:14]; mul_b = $signed({1'b0, alpha_c}); end
      StMulB: begin mul_a = 34'(acur); mul_b = $signed(18'(OneQ16 - alpha_c)); end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
    bnext = blend_q + 66'(prod_q);
    bshift = 50'(bnext >>> 16);
  end

  logic signed [15:0] rsel;
  logic signed [37:0] rdt;
  always_comb begin
    unique case (ch_q)
      2'd0: rsel = smp_q.rate_x;
      2'd1: rsel = smp_q.rate_y;
      default: rsel = smp_q.rate_z;
    endcase
    rdt = rsel * $signed({1'b0, dt_q});
  end

  assign out_free = !out_v_q || out_if.ready;

  always_comb begin
    st_d = st_q; ch_d = ch_q; cstart = 1'b0;
    cy = 17'(smp_q.acc_y); cx = 17'(smp_q.acc_z);
    unique case (st_q)
      StIdle: if (in_if.valid) st_d = en_q ? StRoll : StOut;
      StRoll: begin cstart = 1'b1; st_d = StRollWait; end
      StRollWait: if (cctrl.done) st_d = StPitch;
      StPitch: begin
        cstart = 1'b1; cy = -17'(smp_q.acc_x); st_d = StPitchWait;
      end
      StPitchWait: if (cctrl.done) begin st_d = StGyro; ch_d = 2'd0; end
      StGyro: begin
        if (ch_q == 2'd2) begin st_d = StGyroSum; ch_d = 2'd0; end
        else ch_d = ch_q + 1'b1;
      end
      StGyroSum: st_d = StMulA;
      StMulA: st_d = StMulB;
      StMulB: st_d = StBlend;
      StBlend: begin
        if (ch_q == 2'd2) st_d = StOut;
        else begin ch_d = ch_q + 1'b1; st_d = StMulA; end
      end
      // The result waits here until the output register is free.
      StOut: if (out_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // The multiply on the gyro term runs in two halves: low 14 bits by alpha
  // are folded in exactly through the separate low product below.
  logic signed [31:0] glo_prod;
  assign glo_prod = $signed({1'b0, gcur[13:0]}) * $signed({1'b0, alpha_c});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ch_q <= '0; out_v_q <= 1'b0;
      acc_q[0] <= '0; acc_q[1] <= '0; acc_q[2] <= '0;
    end else begin
      st_q <= st_d; ch_q <= ch_d;
      if (out_if.valid && out_if.ready) out_v_q <= 1'b0;
      if (st_q == StOut && out_free) out_v_q <= 1'b1;
      if (st_q == StBlend) begin
        if (bshift > 50'sd2147483647) acc_q[ch_q] <= 32'sh7fffffff;
        else if (bshift < -50'sd2147483648) acc_q[ch_q] <= 32'sh80000000;
        else acc_q[ch_q] <= bshift[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) smp_q <= in_if.data;
    if (st_q == StRollWait && cctrl.done) ang_q[0] <= cang;
    if (st_q == StPitchWait && cctrl.done) ang_q[1] <= cang;
    if (st_q == StGyro)
      gsum_q[ch_q] <= 48'(acc_q[ch_q]) + 48'((48'(rdt) + 48'sd128) >>> 8);
    unique case (st_q)
      StMulA: begin
        prod_q <= 52'(mul_p) <<< 14;
        blend_q <= 66'(glo_prod) + 66'sd32768;
      end
      StMulB: begin prod_q <= mul_p; blend_q <= bnext; end
      StBlend: blend_q <= bnext;
      default: ;
    endcase
    if (st_q == StOut && out_free)
      out_q <= '{roll_deg: acc_q[0], pitch_deg: acc_q[1], yaw_deg: acc_q[2]};
  end

  assign in_if.ready  = (st_q == StIdle);
  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;

  `IMU_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_if.ready, st_q == StIdle, "ready outside idle")
  `IMU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_v_q && !out_if.ready, out_v_q && $stable(out_q), "result dropped")
  `IMU_ASSERT_NEXT(a_out_wait, clk_i, rst_ni, st_q == StOut && !out_free, st_q == StOut, "result overwritten")
  `IMU_ASSERT_NEXT(a_out_set, clk_i, rst_ni, st_q == StOut, out_v_q, "result not posted")
endmodule

/* rtl/core/imucf_cordic.sv */
// ----------------------------------------------------------------------------
// imucf_cordic
// Iterative CORDIC vectoring unit: atan2(y, x) in Q16.16 degrees.
// ----------------------------------------------------------------------------
`include "imu_complementary_filter_macros.svh"
module imucf_cordic #(
  parameter int unsigned AtanIterations = imucf_pkg::AtanIterDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [16:0]        y_i,
  input  logic signed [16:0]        x_i,
  output imucf_pkg::cordic_ctrl_t   ctrl_o,
  output logic signed [31:0]        angle_o
);
  import imucf_pkg::*;

  localparam int unsigned IterW = 5;
  localparam logic [IterW-1:0] LastIter = IterW'(AtanIterations - 1);

  // x grows by at most about 1.65; 17 bits plus 14 scale plus margin.
  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [31:0] z_q, z_d;
  logic [IterW-1:0]   it_q, it_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic signed [33:0] xs, ys, dx, dy;

  always_comb begin
    xs = 34'(x_i) <<< 14;
    ys = 34'(y_i) <<< 14;
    dx = y_q >>> it_q;
    dy = x_q >>> it_q;
    x_d = x_q; y_d = y_q; z_d = z_q; it_d = it_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      it_d = '0;
      if (x_i == 17'sd0 && y_i == 17'sd0) begin
        z_d = '0; done_d = 1'b1; busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
        if (x_i < 0) begin
          if (y_i >= 0) begin
            x_d = ys; y_d = -xs; z_d = Deg90Q16;
          end else begin
            x_d = -ys; y_d = xs; z_d = -Deg90Q16;
          end
        end else begin
          x_d = xs; y_d = ys; z_d = '0;
        end
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + atan_deg(it_q);
      end else begin
        x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - atan_deg(it_q);
      end
      it_d = it_q + 1'b1;
      if (it_q == LastIter) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; it_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  assign ctrl_o  = '{start: start_i, busy: busy_q, done: done_q};
  assign angle_o = z_q;

  `IMU_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q || start_i, "done held")
  `IMU_ASSERT_IMPL(a_busy_done, clk_i, rst_ni, busy_q, !done_q, "busy and done together")
  `IMU_ASSERT_IMPL(a_iter_range, clk_i, rst_ni, busy_q, it_q <= LastIter, "iteration overrun")
endmodule
